>>> rtl/sllf_pkg.sv
`timescale 1ns / 1ps
package sllf_pkg;

  localparam int NUM_LAYERS   = 6;
  localparam int FRAC_BITS    = 8;
  localparam int CENT_W       = 6;
  localparam int SPAN_W       = 6;
  localparam int OUT_W        = 16;
  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(37);

  localparam int N_W   = 3;
  localparam int X_W   = 5;
  localparam int Y_W   = 7;
  localparam int SX_W  = 6;
  localparam int SY_W  = 10;
  localparam int SXX_W = 8;
  localparam int SXY_W = 12;
  localparam int D_W   = 12;
  localparam int P_W   = 16;
  localparam int NUM_W = 32;
  localparam int DEN_W = 12;
  localparam int DV_W  = DEN_W + 1;
  localparam int QW    = 17;

  localparam int FRONT_STAGES = 4;
  localparam int PIPE = 1 + FRONT_STAGES + QW;

  typedef struct packed {
    logic              pattern_valid;
    logic [CENT_W-1:0] centroid_layer0;
    logic [CENT_W-1:0] centroid_layer1;
    logic [CENT_W-1:0] centroid_layer2;
    logic [CENT_W-1:0] centroid_layer3;
    logic [CENT_W-1:0] centroid_layer4;
    logic [CENT_W-1:0] centroid_layer5;
  } seg_t;

  typedef struct packed {
    logic                    fit_done;
    logic                    fit_error;
    logic signed [OUT_W-1:0] bend_slope;
    logic signed [OUT_W-1:0] substrip_offset;
  } fit_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DV_W-1:0]  dv;
    logic             neg;
    logic             big;
  } div_in_t;

  typedef struct packed {
    logic [QW-1:0] quo;
    logic          neg;
    logic          big;
  } div_out_t;

endpackage

>>> rtl/sllf_front.sv
`timescale 1ns / 1ps
module sllf_front (
  input  logic                                clk,
  input  logic [sllf_pkg::FRONT_STAGES-1:0]   en,
  input  sllf_pkg::seg_t                      item,
  input  logic [sllf_pkg::SPAN_W-1:0]         win_span,
  output logic                                err,
  output sllf_pkg::div_in_t                   m_div,
  output sllf_pkg::div_in_t                   b_div
);

  function automatic sllf_pkg::div_in_t prep(input logic signed [sllf_pkg::NUM_W-1:0] num,
                                             input logic [sllf_pkg::DEN_W-1:0] den);
    sllf_pkg::div_in_t r;
    logic [sllf_pkg::NUM_W-1:0] mag;
    logic [sllf_pkg::NUM_W-1:0] lim;
    r.neg = num[sllf_pkg::NUM_W-1];
    mag   = r.neg ? sllf_pkg::NUM_W'(-num) : sllf_pkg::NUM_W'(num);
    r.dv  = {den, 1'b0};
    r.rem = (mag << 1) + sllf_pkg::NUM_W'(den);
    lim   = sllf_pkg::NUM_W'(r.dv) << sllf_pkg::QW;
    r.big = r.rem >= lim;
    return r;
  endfunction

  logic [sllf_pkg::CENT_W-1:0] cent [sllf_pkg::NUM_LAYERS];
  logic [sllf_pkg::CENT_W-1:0] offset;

  assign cent[0] = item.centroid_layer0;
  assign cent[1] = item.centroid_layer1;
  assign cent[2] = item.centroid_layer2;
  assign cent[3] = item.centroid_layer3;
  assign cent[4] = item.centroid_layer4;
  assign cent[5] = item.centroid_layer5;
  assign offset  = {1'b0, win_span[sllf_pkg::SPAN_W-1:1]} + sllf_pkg::CENT_W'(1);

  logic [sllf_pkg::N_W-1:0]          n_next;
  logic signed [sllf_pkg::SX_W-1:0]  sx_next;
  logic signed [sllf_pkg::SY_W-1:0]  sy_next;
  logic [sllf_pkg::SXX_W-1:0]        sxx_next;
  logic signed [sllf_pkg::SXY_W-1:0] sxy_next;

  always_comb begin
    logic signed [sllf_pkg::X_W-1:0]   x;
    logic signed [sllf_pkg::Y_W-1:0]   y;
    logic signed [sllf_pkg::SXY_W-1:0] xw;
    logic signed [sllf_pkg::SXY_W-1:0] yw;
    n_next   = '0;
    sx_next  = '0;
    sy_next  = '0;
    sxx_next = '0;
    sxy_next = '0;
    for (int i = 0; i < sllf_pkg::NUM_LAYERS; i++) begin
      x  = sllf_pkg::X_W'(2 * i - (sllf_pkg::NUM_LAYERS - 1));
      y  = $signed({1'b0, cent[i]}) - $signed({1'b0, offset});
      xw = sllf_pkg::SXY_W'(x);
      yw = sllf_pkg::SXY_W'(y);
      if (cent[i] != '0) begin
        n_next   = n_next + sllf_pkg::N_W'(1);
        sx_next  = sx_next + sllf_pkg::SX_W'(x);
        sy_next  = sy_next + sllf_pkg::SY_W'(y);
        sxx_next = sxx_next + sllf_pkg::SXX_W'(xw * xw);
        sxy_next = sxy_next + sllf_pkg::SXY_W'(xw * yw);
      end
    end
  end

  logic [sllf_pkg::N_W-1:0]          n1;
  logic signed [sllf_pkg::SX_W-1:0]  sx1;
  logic signed [sllf_pkg::SY_W-1:0]  sy1;
  logic [sllf_pkg::SXX_W-1:0]        sxx1;
  logic signed [sllf_pkg::SXY_W-1:0] sxy1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n1   <= n_next;
      sx1  <= sx_next;
      sy1  <= sy_next;
      sxx1 <= sxx_next;
      sxy1 <= sxy_next;
      err  <= n_next < sllf_pkg::N_W'(2);
    end
  end

  logic signed [12:0] nsxx;
  logic signed [12:0] sxsq;
  logic signed [16:0] nsxy;
  logic signed [16:0] sxsy;

  assign nsxx = $signed({1'b0, n1}) * $signed({1'b0, sxx1});
  assign sxsq = sx1 * sx1;
  assign nsxy = $signed({1'b0, n1}) * sxy1;
  assign sxsy = sx1 * sy1;

  logic [sllf_pkg::N_W-1:0]         n2;
  logic signed [sllf_pkg::SX_W-1:0] sx2;
  logic signed [sllf_pkg::SY_W-1:0] sy2;
  logic signed [sllf_pkg::D_W-1:0]  dd2;
  logic signed [sllf_pkg::P_W-1:0]  pp2;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n2  <= n1;
      sx2 <= sx1;
      sy2 <= sy1;
      dd2 <= sllf_pkg::D_W'(nsxx - sxsq);
      pp2 <= sllf_pkg::P_W'(nsxy - sxsy);
    end
  end

  logic signed [22:0] syd;
  logic signed [22:0] psx;
  logic signed [22:0] bdiff;
  logic [sllf_pkg::DEN_W-1:0] dpos;

  assign syd   = sy2 * dd2;
  assign psx   = pp2 * sx2;
  assign bdiff = syd - psx;
  assign dpos  = $unsigned(dd2);

  logic signed [sllf_pkg::NUM_W-1:0] mnum3;
  logic signed [sllf_pkg::NUM_W-1:0] bnum3;
  logic [sllf_pkg::DEN_W-1:0]        mden3;
  logic [sllf_pkg::DEN_W-1:0]        bden3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mnum3 <= sllf_pkg::NUM_W'(pp2) <<< (sllf_pkg::FRAC_BITS + 1);
      bnum3 <= sllf_pkg::NUM_W'(bdiff) <<< sllf_pkg::FRAC_BITS;
      mden3 <= dpos;
      bden3 <= sllf_pkg::DEN_W'({{(sllf_pkg::DEN_W - sllf_pkg::N_W){1'b0}}, n2} * dpos);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m_div <= prep(mnum3, mden3);
      b_div <= prep(bnum3, bden3);
    end
  end

endmodule

>>> rtl/sllf_div.sv
`timescale 1ns / 1ps
module sllf_div (
  input  logic                      clk,
  input  logic [sllf_pkg::QW-1:0]   en,
  input  sllf_pkg::div_in_t         din,
  output sllf_pkg::div_out_t        dout
);

  logic [sllf_pkg::NUM_W-1:0] rem  [sllf_pkg::QW];
  logic [sllf_pkg::DV_W-1:0]  dv   [sllf_pkg::QW];
  logic [sllf_pkg::QW-1:0]    quo  [sllf_pkg::QW];
  logic                       neg  [sllf_pkg::QW];
  logic                       big  [sllf_pkg::QW];

  for (genvar j = 0; j < sllf_pkg::QW; j++) begin : g_stage
    logic [sllf_pkg::NUM_W-1:0] rem_in;
    logic [sllf_pkg::DV_W-1:0]  dv_in;
    logic [sllf_pkg::QW-1:0]    quo_in;
    logic                       neg_in;
    logic                       big_in;
    logic [sllf_pkg::NUM_W-1:0] trial;

    if (j == 0) begin : g_first
      assign rem_in = din.rem;
      assign dv_in  = din.dv;
      assign quo_in = '0;
      assign neg_in = din.neg;
      assign big_in = din.big;
    end else begin : g_rest
      assign rem_in = rem[j-1];
      assign dv_in  = dv[j-1];
      assign quo_in = quo[j-1];
      assign neg_in = neg[j-1];
      assign big_in = big[j-1];
    end

    assign trial = sllf_pkg::NUM_W'(dv_in) << (sllf_pkg::QW - 1 - j);

    always_ff @(posedge clk) begin
      if (en[j]) begin
        if (rem_in >= trial) begin
          rem[j] <= rem_in - trial;
          quo[j] <= quo_in | (sllf_pkg::QW'(1) << (sllf_pkg::QW - 1 - j));
        end else begin
          rem[j] <= rem_in;
          quo[j] <= quo_in;
        end
        dv[j]  <= dv_in;
        neg[j] <= neg_in;
        big[j] <= big_in;
      end
    end
  end

  assign dout.quo = quo[sllf_pkg::QW-1];
  assign dout.neg = neg[sllf_pkg::QW-1];
  assign dout.big = big[sllf_pkg::QW-1] | (rem[sllf_pkg::QW-1] == '1 && 1'b0);

endmodule

>>> rtl/six_layer_line_fit.sv
`timescale 1ns / 1ps
// Least-squares line fit over the hit layers of one segment candidate.
// seg channel: seg_valid/seg_stall with a seg_t beat (pattern flag and six
// per-layer centroids, 0 meaning no hit). A beat is taken when seg_valid is
// high and seg_stall is low.
// fit channel: fit_valid/fit_stall with a fit_t beat (done and error flags,
// slope and intercept in signed fixed point with 8 fraction bits, rounded
// half away from zero and saturated).
// cfg channel: cfg_valid/cfg_ready writes the window span; cfg_ready is
// always high. Write it only while no beat is in flight.
// Throughput: one beat per cycle while seg_stall is low. The path from seg
// acceptance to fit_valid runs through one input register, four fit stages
// (sums, determinants, numerators, rounding prep) and a 17-stage restoring
// divider, one quotient bit per stage, for slope and intercept side by side,
// then the output register.
// Reset clears all valid bits and loads the window span with 37.
// A fit stall holds the output register; the stages behind it keep
// advancing into empty slots and seg_stall rises only once the whole
// pipeline is full.
module six_layer_line_fit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        seg_valid,
  output logic                        seg_stall,
  input  sllf_pkg::seg_t              seg_data,
  output logic                        fit_valid,
  input  logic                        fit_stall,
  output sllf_pkg::fit_t              fit_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sllf_pkg::SPAN_W-1:0] cfg_data
);

  function automatic logic signed [sllf_pkg::OUT_W-1:0] sat(input sllf_pkg::div_out_t d);
    logic signed [sllf_pkg::OUT_W-1:0] r;
    if (d.neg) begin
      if (d.big || d.quo >= sllf_pkg::QW'(32768)) r = 16'sh8000;
      else r = -$signed(sllf_pkg::OUT_W'(d.quo));
    end else begin
      if (d.big || d.quo >= sllf_pkg::QW'(32767)) r = 16'sh7fff;
      else r = $signed(sllf_pkg::OUT_W'(d.quo));
    end
    return r;
  endfunction

  logic [sllf_pkg::SPAN_W-1:0] win_span;
  logic [sllf_pkg::PIPE:0]     en;
  logic [sllf_pkg::PIPE-1:0]   v;
  sllf_pkg::seg_t              item;
  logic                        err1;
  sllf_pkg::div_in_t           m_div;
  sllf_pkg::div_in_t           b_div;
  sllf_pkg::div_out_t          m_out;
  sllf_pkg::div_out_t          b_out;
  logic                        pv_q  [1:sllf_pkg::PIPE-1];
  logic                        err_q [2:sllf_pkg::PIPE-1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_span <= sllf_pkg::SPAN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      win_span <= cfg_data;
    end
  end

  always_comb begin
    en[sllf_pkg::PIPE] = !fit_valid || !fit_stall;
    for (int k = sllf_pkg::PIPE - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign seg_stall = !en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      fit_valid <= 1'b0;
    end else begin
      if (en[0]) v[0] <= seg_valid;
      for (int k = 1; k < sllf_pkg::PIPE; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
      if (en[sllf_pkg::PIPE]) fit_valid <= v[sllf_pkg::PIPE-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) item <= seg_data;
    if (en[1]) pv_q[1] <= item.pattern_valid;
    if (en[2]) begin
      pv_q[2]  <= pv_q[1];
      err_q[2] <= err1;
    end
    for (int k = 3; k < sllf_pkg::PIPE; k++) begin
      if (en[k]) begin
        pv_q[k]  <= pv_q[k-1];
        err_q[k] <= err_q[k-1];
      end
    end
  end

  sllf_front u_front (
    .clk      (clk),
    .en       (en[sllf_pkg::FRONT_STAGES:1]),
    .item     (item),
    .win_span (win_span),
    .err      (err1),
    .m_div    (m_div),
    .b_div    (b_div)
  );

  sllf_div u_div_m (
    .clk  (clk),
    .en   (en[sllf_pkg::PIPE-1:sllf_pkg::FRONT_STAGES+1]),
    .din  (m_div),
    .dout (m_out)
  );

  sllf_div u_div_b (
    .clk  (clk),
    .en   (en[sllf_pkg::PIPE-1:sllf_pkg::FRONT_STAGES+1]),
    .din  (b_div),
    .dout (b_out)
  );

  always_ff @(posedge clk) begin
    if (en[sllf_pkg::PIPE]) begin
      if (!pv_q[sllf_pkg::PIPE-1]) begin
        fit_data <= '0;
      end else if (err_q[sllf_pkg::PIPE-1]) begin
        fit_data.fit_done        <= 1'b1;
        fit_data.fit_error       <= 1'b1;
        fit_data.bend_slope      <= '0;
        fit_data.substrip_offset <= '0;
      end else begin
        fit_data.fit_done        <= 1'b1;
        fit_data.fit_error       <= 1'b0;
        fit_data.bend_slope      <= sat(m_out);
        fit_data.substrip_offset <= sat(b_out);
      end
    end
  end

endmodule

>>> rtl/sllf_checker.sv
`timescale 1ns / 1ps
module sllf_checker (
  input logic           clk,
  input logic           rst,
  input logic           seg_stall,
  input logic           fit_valid,
  input logic           fit_stall,
  input sllf_pkg::fit_t fit_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !fit_valid && !seg_stall)
    else $error("pipeline not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_stall |=> fit_valid && $stable(fit_data))
    else $error("stalled fit beat changed");

  a_no_pattern: assert property (@(posedge clk) disable iff (rst)
    fit_valid && !fit_data.fit_done |->
      !fit_data.fit_error && fit_data.bend_slope == '0 && fit_data.substrip_offset == '0)
    else $error("no-pattern beat carries data");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_data.fit_error |->
      fit_data.fit_done && fit_data.bend_slope == '0 && fit_data.substrip_offset == '0)
    else $error("error beat carries data");

endmodule

bind six_layer_line_fit sllf_checker u_sllf_checker (.*);

>>> tb/six_layer_line_fit_tb.sv
`timescale 1ns / 1ps
module six_layer_line_fit_tb;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 60;

  logic clk = 0;
  logic rst = 1;
  logic seg_valid = 0;
  logic seg_stall;
  sllf_pkg::seg_t seg_data = '0;
  logic fit_valid;
  logic fit_stall = 1;
  sllf_pkg::fit_t fit_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [sllf_pkg::SPAN_W-1:0] cfg_data = '0;

  six_layer_line_fit uut (
    .clk(clk), .rst(rst),
    .seg_valid(seg_valid), .seg_stall(seg_stall), .seg_data(seg_data),
    .fit_valid(fit_valid), .fit_stall(fit_stall), .fit_data(fit_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  sllf_pkg::seg_t pending_segs[$];
  sllf_pkg::fit_t expected_fits[$];
  logic [sllf_pkg::SPAN_W-1:0] span_model = sllf_pkg::SPAN_RESET;
  int mismatches = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  int hold_off = 0;
  bit pause_send = 0;

  function automatic longint round_quot(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic signed [sllf_pkg::OUT_W-1:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[sllf_pkg::OUT_W-1:0];
  endfunction

  function automatic sllf_pkg::fit_t fit_line(sllf_pkg::seg_t s,
                                              logic [sllf_pkg::SPAN_W-1:0] span);
    sllf_pkg::fit_t r;
    longint xs[sllf_pkg::NUM_LAYERS];
    longint ys[sllf_pkg::NUM_LAYERS];
    logic [sllf_pkg::CENT_W-1:0] c[sllf_pkg::NUM_LAYERS];
    longint n, sx, sy, p, q, ofs, dx, dy;
    r = '0;
    n = 0; sx = 0; sy = 0; p = 0; q = 0;
    ofs = longint'(span / 2) + 1;
    c = '{s.centroid_layer0, s.centroid_layer1, s.centroid_layer2,
          s.centroid_layer3, s.centroid_layer4, s.centroid_layer5};
    if (!s.pattern_valid) return r;
    r.fit_done = 1'b1;
    for (int i = 0; i < sllf_pkg::NUM_LAYERS; i++) begin
      if (c[i] != '0) begin
        xs[n] = longint'(2 * i - 5);
        ys[n] = longint'(c[i]) - ofs;
        sx += xs[n];
        sy += ys[n];
        n++;
      end
    end
    if (n < 2) begin
      r.fit_error = 1'b1;
      return r;
    end
    for (int i = 0; i < n; i++) begin
      dx = n * xs[i] - sx;
      dy = n * ys[i] - sy;
      p += dx * dy;
      q += dx * dx;
    end
    r.bend_slope = clamp16(round_quot(2 * p * (64'sd1 <<< sllf_pkg::FRAC_BITS), q));
    r.substrip_offset =
      clamp16(round_quot((sy * q - p * sx) * (64'sd1 <<< sllf_pkg::FRAC_BITS), n * q));
    return r;
  endfunction

  function automatic sllf_pkg::seg_t rand_seg();
    sllf_pkg::seg_t s;
    logic [sllf_pkg::CENT_W-1:0] c[sllf_pkg::NUM_LAYERS];
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < sllf_pkg::NUM_LAYERS; i++) begin
      c[i] = sllf_pkg::CENT_W'($urandom_range(0, 63));
      if (mode < 3 && $urandom_range(0, 2) == 0) c[i] = '0;
      if (mode == 3 && $urandom_range(0, 1) == 0) c[i] = '0;
      if (mode == 4) c[i] = (i == $urandom_range(0, 5)) ? c[i] : '0;
    end
    s.pattern_valid = ($urandom_range(0, 9) != 0);
    {s.centroid_layer0, s.centroid_layer1, s.centroid_layer2,
     s.centroid_layer3, s.centroid_layer4, s.centroid_layer5} =
      {c[0], c[1], c[2], c[3], c[4], c[5]};
    return s;
  endfunction

  function automatic sllf_pkg::seg_t make_seg(bit pv, int c0, int c1, int c2, int c3,
                                              int c4, int c5);
    sllf_pkg::seg_t s;
    s.pattern_valid = pv;
    s.centroid_layer0 = sllf_pkg::CENT_W'(c0);
    s.centroid_layer1 = sllf_pkg::CENT_W'(c1);
    s.centroid_layer2 = sllf_pkg::CENT_W'(c2);
    s.centroid_layer3 = sllf_pkg::CENT_W'(c3);
    s.centroid_layer4 = sllf_pkg::CENT_W'(c4);
    s.centroid_layer5 = sllf_pkg::CENT_W'(c5);
    return s;
  endfunction

  task automatic add_seg(sllf_pkg::seg_t s);
    pending_segs = {pending_segs, s};
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      seg_valid <= 0;
    end else if (seg_valid && !seg_stall) begin
      expected_fits = {expected_fits, fit_line(seg_data, span_model)};
      void'(pending_segs.pop_front());
      if (pending_segs.size() > 0 && !pause_send && (quiet || $urandom_range(0, 99) >= 30))
      begin
        seg_data <= pending_segs[0];
        seg_valid <= 1;
      end else begin
        seg_valid <= 0;
      end
    end else if (!seg_valid && pending_segs.size() > 0 && !pause_send &&
                 (quiet || $urandom_range(0, 99) >= 30)) begin
      seg_data <= pending_segs[0];
      seg_valid <= 1;
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (rst) begin
      fit_stall <= 1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      fit_stall <= 1;
    end else begin
      fit_stall <= !quiet && ($urandom_range(0, 99) < 30);
    end
  end

  // monitor
  always @(posedge clk) begin
    sllf_pkg::fit_t want;
    if (!rst && fit_valid && !fit_stall) begin
      if (expected_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", fit_data);
      end else begin
        want = expected_fits.pop_front();
        if (fit_data.fit_done !== want.fit_done || fit_data.fit_error !== want.fit_error ||
            fit_data.bend_slope !== want.bend_slope ||
            fit_data.substrip_offset !== want.substrip_offset) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected done=%0d err=%0d slope=%0d ofs=%0d, got %0d %0d %0d %0d",
                     want.fit_done, want.fit_error, want.bend_slope, want.substrip_offset,
                     fit_data.fit_done, fit_data.fit_error, fit_data.bend_slope,
                     fit_data.substrip_offset);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (seg_valid && !seg_stall) || (fit_valid && !fit_stall) || hold_off > 0)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("six_layer_line_fit regression: fail");
      $finish;
    end
  end

  task automatic drain();
    while (pending_segs.size() > 0 || seg_valid || expected_fits.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_span(logic [sllf_pkg::SPAN_W-1:0] v);
    @(posedge clk);
    cfg_data <= v;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    span_model = v;
  endtask

  initial begin
    logic [sllf_pkg::SPAN_W-1:0] spans[6];
    spans = '{sllf_pkg::SPAN_RESET, 6'd63, 6'd0, 6'd1, 6'd20, 6'd63};
    repeat (9) @(posedge clk);
    rst <= 0;

    add_seg(make_seg(0, 5, 6, 7, 8, 9, 10));
    add_seg(make_seg(1, 0, 0, 0, 0, 0, 0));
    add_seg(make_seg(1, 0, 0, 30, 0, 0, 0));
    add_seg(make_seg(1, 1, 0, 0, 0, 0, 63));
    add_seg(make_seg(1, 63, 63, 63, 63, 63, 63));
    add_seg(make_seg(1, 1, 1, 1, 1, 1, 1));
    add_seg(make_seg(1, 63, 0, 0, 0, 0, 1));
    add_seg(make_seg(1, 1, 63, 0, 0, 0, 0));
    add_seg(make_seg(1, 0, 0, 0, 0, 63, 1));
    add_seg(make_seg(1, 1, 63, 1, 63, 1, 63));
    add_seg(make_seg(1, 10, 12, 14, 16, 18, 20));
    add_seg(make_seg(1, 0, 0, 1, 2, 0, 0));
    add_seg(make_seg(0, 63, 63, 63, 63, 63, 63));
    add_seg(make_seg(1, 42, 21, 0, 0, 21, 42));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_span(spans[ph]);
      quiet = (ph == 1);
      for (int k = 0; k < 320; k++) add_seg(rand_seg());
      if (ph == 2) begin
        while (pending_segs.size() > 250) @(posedge clk);
        hold_off <= 200;
        @(posedge clk);
      end
      if (ph == 4) begin
        while (pending_segs.size() > 160) @(posedge clk);
        pause_send = 1;
        while (seg_valid || expected_fits.size() > 0) @(posedge clk);
        pause_send = 0;
      end
      drain();
    end

    if (mismatches == 0)
      $display("six_layer_line_fit regression: pass");
    else
      $display("six_layer_line_fit regression: fail");
    $finish;
  end
endmodule
